[design/gmc_pkg.sv]
// Shared types and constants for the graph m-coloring search unit.
// Holds the transaction structs, memory control struct and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gmc_pkg;

    // Default sizes of the graph and the color set.
    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_COLORS_DEF   = 15;

    // Fixed field widths on the ports.
    localparam int VERTEX_W    = 4;
    localparam int COLOR_W     = 4;
    localparam int VCOUNT_W    = 5;
    localparam int CCOUNT_W    = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Register reset values.
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 4'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VERTEX_COUNT = 2'd0,
        REG_COLOR_COUNT  = 2'd1
    } cfg_reg_t;

    // Item operation codes.
    typedef enum logic {
        OP_ADD_EDGE = 1'b0,
        OP_SOLVE    = 1'b1
    } op_t;

    // Input item transaction.
    typedef struct packed {
        logic                operation;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } gmc_item_t;

    // Result transaction.
    typedef struct packed {
        logic                found;
        logic [VERTEX_W-1:0] vertex_index;
        logic [COLOR_W-1:0]  vertex_color;
        logic                last;
    } gmc_result_t;

    // Strobes from the search controller to one memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

[design/gmc_adj_mem.sv]
// Adjacency bit matrix memory with one write and one registered read port.
// Rows carry valid bits so that reset clears the matrix at once.
// Depends on gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_adj_mem #(
    parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF,
    localparam int VertW = $clog2(MAX_VERTICES)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire gmc_pkg::mem_ctl_t       ctl,
    input  wire logic [VertW-1:0]        wr_row,
    input  wire logic [VertW-1:0]        wr_col,
    input  wire logic [VertW-1:0]        rd_row,
    output logic [MAX_VERTICES-1:0]      rd_data
);
    import gmc_pkg::*;

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] rd_raw_reg;
    logic                    rd_valid_reg;

    // A row never written since reset takes a whole-row write; later edges set one bit.
    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            if (!row_valid_reg[wr_row]) begin
                mem[wr_row] <= MAX_VERTICES'(1) << wr_col;
            end
            else begin
                mem[wr_row][wr_col] <= 1'b1;
            end
        end
        if (ctl.rd_en) begin
            rd_raw_reg <= mem[rd_row];
        end
    end

    // Row valid bits and the valid flag of the registered read.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else begin
            if (ctl.wr_en) begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
        end
    end

    // A row that was never written reads as no neighbors.
    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

[design/gmc_color_mem.sv]
// Vertex color memory, one write port and one registered read port.
// Entries are written by the search before their read data is used.
// Depends on gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_color_mem #(
    parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = gmc_pkg::MAX_COLORS_DEF,
    localparam int VertW  = $clog2(MAX_VERTICES),
    localparam int ColorW = $clog2(MAX_COLORS + 1)
) (
    input  wire logic              clk,
    input  wire gmc_pkg::mem_ctl_t ctl,
    input  wire logic [VertW-1:0]  wr_addr,
    input  wire logic [ColorW-1:0] wr_data,
    input  wire logic [VertW-1:0]  rd_addr,
    output logic [ColorW-1:0]      rd_data
);
    import gmc_pkg::*;

    logic [ColorW-1:0] mem [MAX_VERTICES];
    logic [ColorW-1:0] rd_data_reg;

    // Synchronous write and read; read data holds until the next read.
    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/gmc_search.sv]
// Search controller: edge loading, backtracking sequencer and result register.
// Drives the adjacency and color memories through mem_ctl_t strobes.
// Depends on gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_search #(
    parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = gmc_pkg::MAX_COLORS_DEF,
    localparam int VertW  = $clog2(MAX_VERTICES),
    localparam int ColorW = $clog2(MAX_COLORS + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire gmc_pkg::gmc_item_t             item_data,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output gmc_pkg::gmc_result_t                result_data,
    input  wire logic [gmc_pkg::VCOUNT_W-1:0]   vertex_count,
    input  wire logic [gmc_pkg::CCOUNT_W-1:0]   color_count,
    output gmc_pkg::mem_ctl_t                   adj_ctl,
    output logic [VertW-1:0]                    adj_wr_row,
    output logic [VertW-1:0]                    adj_wr_col,
    output logic [VertW-1:0]                    adj_rd_row,
    input  wire logic [MAX_VERTICES-1:0]        adj_rd_data,
    output gmc_pkg::mem_ctl_t                   col_ctl,
    output logic [VertW-1:0]                    col_wr_addr,
    output logic [ColorW-1:0]                   col_wr_data,
    output logic [VertW-1:0]                    col_rd_addr,
    input  wire logic [ColorW-1:0]              col_rd_data
);
    import gmc_pkg::*;

    localparam int CntW  = VertW + 1;
    localparam int UsedW = MAX_COLORS + 1;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EDGE     = 8'b0000_0010,
        S_VISIT    = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_PICK     = 8'b0001_0000,
        S_OUT_READ = 8'b0010_0000,
        S_OUT_LOAD = 8'b0100_0000,
        S_FAIL     = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [VertW-1:0]  v_reg, v_next;
    logic [CntW-1:0]   n_reg, n_next;
    logic [ColorW-1:0] m_reg, m_next;
    logic [VertW-1:0]  scan_w_reg, scan_w_next;
    logic              pend_reg, pend_next;
    logic [VertW-1:0]  pend_w_reg, pend_w_next;
    logic              first_reg, first_next;
    logic              back_reg, back_next;
    logic [ColorW-1:0] start_reg, start_next;
    logic [UsedW-1:0]  used_reg, used_next;
    logic [VertW-1:0]  k_reg, k_next;
    logic [VertW-1:0]  ea_reg, ea_next;
    logic [VertW-1:0]  eb_reg, eb_next;
    logic              result_valid_reg, result_valid_next;
    gmc_result_t       result_data_reg, result_data_next;

    logic              item_take;
    logic              edge_in_range;
    logic [CntW-1:0]   n_sat;
    logic [ColorW-1:0] m_sat;
    logic              pick_found;
    logic [ColorW-1:0] pick_color;
    logic              result_load;
    logic              k_is_last;
    logic              v_is_last;

    // Handshake on the item side: items are taken only between searches.
    assign item_stall = (state_reg != S_IDLE);
    assign item_take  = item_valid && !item_stall;

    // The result register may take a new transaction when empty or draining.
    assign result_load = !result_valid_reg || !result_stall;

    assign edge_in_range = (int'(item_data.vertex_a) < MAX_VERTICES) &&
                           (int'(item_data.vertex_b) < MAX_VERTICES);

    assign k_is_last = ((CntW'(k_reg) + CntW'(1)) == n_reg);
    assign v_is_last = ((CntW'(v_reg) + CntW'(1)) == n_reg);

    // Clamp the register values for a new search.
    always_comb begin
        if (vertex_count == '0) begin
            n_sat = CntW'(1);
        end
        else if (int'(vertex_count) > MAX_VERTICES) begin
            n_sat = CntW'(MAX_VERTICES);
        end
        else begin
            n_sat = CntW'(vertex_count);
        end
        if (int'(color_count) > MAX_COLORS) begin
            m_sat = ColorW'(MAX_COLORS);
        end
        else begin
            m_sat = ColorW'(color_count);
        end
    end

    // Lowest color above the current one that no earlier neighbor holds.
    always_comb begin
        pick_found = 1'b0;
        pick_color = '0;
        for (int c = MAX_COLORS; c >= 1; c--) begin
            if (!used_reg[c] && (ColorW'(c) > start_reg) && (ColorW'(c) <= m_reg)) begin
                pick_found = 1'b1;
                pick_color = ColorW'(c);
            end
        end
    end

    // Sequencer and memory strobes.
    always_comb begin
        state_next        = state_reg;
        v_next            = v_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        scan_w_next       = scan_w_reg;
        pend_next         = pend_reg;
        pend_w_next       = pend_w_reg;
        first_next        = first_reg;
        back_next         = back_reg;
        start_next        = start_reg;
        used_next         = used_reg;
        k_next            = k_reg;
        ea_next           = ea_reg;
        eb_next           = eb_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_data_next  = result_data_reg;

        adj_ctl     = '0;
        adj_wr_row  = VertW'(item_data.vertex_a);
        adj_wr_col  = VertW'(item_data.vertex_b);
        adj_rd_row  = v_reg;
        col_ctl     = '0;
        col_wr_addr = v_reg;
        col_wr_data = pick_color;
        col_rd_addr = v_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (item_take) begin
                    if (item_data.operation == OP_SOLVE) begin
                        n_next     = n_sat;
                        m_next     = m_sat;
                        v_next     = '0;
                        back_next  = 1'b0;
                        state_next = S_VISIT;
                    end
                    else if (edge_in_range) begin
                        // First half of the edge: row a gets bit b.
                        adj_ctl.wr_en = 1'b1;
                        ea_next       = VertW'(item_data.vertex_a);
                        eb_next       = VertW'(item_data.vertex_b);
                        state_next    = S_EDGE;
                    end
                end
            end

            S_EDGE: begin
                // Second half of the edge: row b gets bit a.
                adj_ctl.wr_en = 1'b1;
                adj_wr_row    = eb_reg;
                adj_wr_col    = ea_reg;
                state_next    = S_IDLE;
            end

            S_VISIT: begin
                // Fetch the neighbor row and the vertex's own color.
                adj_ctl.rd_en = 1'b1;
                col_ctl.rd_en = 1'b1;
                scan_w_next   = '0;
                pend_next     = 1'b0;
                first_next    = 1'b1;
                used_next     = '0;
                state_next    = S_SCAN;
            end

            S_SCAN: begin
                // The first read returns the vertex's own color.
                if (first_reg) begin
                    start_next = back_reg ? col_rd_data : '0;
                    first_next = 1'b0;
                end
                // Collect the colors of earlier neighbors.
                if (pend_reg && adj_rd_data[pend_w_reg] && (col_rd_data != '0)) begin
                    used_next = used_reg | (UsedW'(1) << col_rd_data);
                end
                if (scan_w_reg == v_reg) begin
                    pend_next  = 1'b0;
                    state_next = S_PICK;
                end
                else begin
                    col_ctl.rd_en = 1'b1;
                    col_rd_addr   = scan_w_reg;
                    pend_next     = 1'b1;
                    pend_w_next   = scan_w_reg;
                    scan_w_next   = scan_w_reg + VertW'(1);
                end
            end

            S_PICK: begin
                if (pick_found) begin
                    col_ctl.wr_en = 1'b1;
                    if (v_is_last) begin
                        k_next     = '0;
                        state_next = S_OUT_READ;
                    end
                    else begin
                        v_next     = v_reg + VertW'(1);
                        back_next  = 1'b0;
                        state_next = S_VISIT;
                    end
                end
                else if (v_reg == '0) begin
                    state_next = S_FAIL;
                end
                else begin
                    v_next     = v_reg - VertW'(1);
                    back_next  = 1'b1;
                    state_next = S_VISIT;
                end
            end

            S_OUT_READ: begin
                col_ctl.rd_en = 1'b1;
                col_rd_addr   = k_reg;
                state_next    = S_OUT_LOAD;
            end

            S_OUT_LOAD: begin
                if (result_load) begin
                    result_valid_next             = 1'b1;
                    result_data_next.found        = 1'b1;
                    result_data_next.vertex_index = VERTEX_W'(k_reg);
                    result_data_next.vertex_color = COLOR_W'(col_rd_data);
                    result_data_next.last         = k_is_last;
                    if (k_is_last) begin
                        state_next = S_IDLE;
                    end
                    else begin
                        k_next     = k_reg + VertW'(1);
                        state_next = S_OUT_READ;
                    end
                end
            end

            S_FAIL: begin
                if (result_load) begin
                    result_valid_next             = 1'b1;
                    result_data_next.found        = 1'b0;
                    result_data_next.vertex_index = '0;
                    result_data_next.vertex_color = '0;
                    result_data_next.last         = 1'b1;
                    state_next                    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            pend_reg         <= 1'b0;
            first_reg        <= 1'b0;
            back_reg         <= 1'b0;
        end
        else begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            pend_reg         <= pend_next;
            first_reg        <= first_next;
            back_reg         <= back_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        v_reg           <= v_next;
        n_reg           <= n_next;
        m_reg           <= m_next;
        scan_w_reg      <= scan_w_next;
        pend_w_reg      <= pend_w_next;
        start_reg       <= start_next;
        used_reg        <= used_next;
        k_reg           <= k_next;
        ea_reg          <= ea_next;
        eb_reg          <= eb_next;
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // The search position stays inside the vertex range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VISIT || state_reg == S_SCAN || state_reg == S_PICK)
            |-> (CntW'(v_reg) < n_reg))
        else $error("search vertex outside the vertex range");

    // Only a color from 1 to the color count is ever stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        col_ctl.wr_en |-> (col_wr_data != '0) && (col_wr_data <= m_reg))
        else $error("stored color out of range");

    // A not-found transaction is always the last of its solve.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_data.found) |-> result_data.last)
        else $error("not-found result without last");

    // The second half of an edge follows directly on its first half.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE) |-> ($past(state_reg) == S_IDLE))
        else $error("edge write without an accepted edge");

endmodule

`default_nettype wire

[design/graph_m_coloring_search_unit.sv]
// Top level of the graph m-coloring search unit: configuration registers
// and the adjacency memory, color memory and search controller.
// Depends on gmc_pkg, gmc_adj_mem, gmc_color_mem and gmc_search.
//
//  Channel  | Signals                           | Direction | Transaction
//  ---------+-----------------------------------+-----------+-----------------------------
//  item     | item_valid, item_stall, item_data | in        | add an edge or start a solve
//  result   | result_valid, result_stall, ...   | out       | one vertex color or not-found
//  cfg      | cfg_valid, cfg_ready, cfg_index,  | in        | write vertex or color count
//           | cfg_data                          |           |
//
// An edge makes one write to each of the two adjacency rows.
// A solve visits vertices one at a time; a visit to vertex v scans the earlier
// vertices through the single read port of the color memory.
// Each result is a color read, then a load of the output register.
// Reset clears the adjacency matrix at once through per-row valid bits.
// The result register holds a stalled transaction; the search waits for it.
`timescale 1ns / 1ps
`default_nettype none

module graph_m_coloring_search_unit #(
    parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = gmc_pkg::MAX_COLORS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire gmc_pkg::gmc_item_t                item_data,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output gmc_pkg::gmc_result_t                   result_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [gmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gmc_pkg::*;

    localparam int VertW  = $clog2(MAX_VERTICES);
    localparam int ColorW = $clog2(MAX_COLORS + 1);

    logic [VCOUNT_W-1:0]     vertex_count_reg;
    logic [CCOUNT_W-1:0]     color_count_reg;

    mem_ctl_t                adj_ctl;
    logic [VertW-1:0]        adj_wr_row;
    logic [VertW-1:0]        adj_wr_col;
    logic [VertW-1:0]        adj_rd_row;
    logic [MAX_VERTICES-1:0] adj_rd_data;
    mem_ctl_t                col_ctl;
    logic [VertW-1:0]        col_wr_addr;
    logic [ColorW-1:0]       col_wr_data;
    logic [VertW-1:0]        col_rd_addr;
    logic [ColorW-1:0]       col_rd_data;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vertex_count_reg <= VCOUNT_RESET;
            color_count_reg  <= CCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_VERTEX_COUNT: vertex_count_reg <= VCOUNT_W'(cfg_data);
                REG_COLOR_COUNT:  color_count_reg  <= CCOUNT_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    gmc_adj_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (adj_ctl),
        .wr_row  (adj_wr_row),
        .wr_col  (adj_wr_col),
        .rd_row  (adj_rd_row),
        .rd_data (adj_rd_data)
    );

    gmc_color_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_COLORS   (MAX_COLORS)
    ) u_color_mem (
        .clk     (clk),
        .ctl     (col_ctl),
        .wr_addr (col_wr_addr),
        .wr_data (col_wr_data),
        .rd_addr (col_rd_addr),
        .rd_data (col_rd_data)
    );

    gmc_search #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_COLORS   (MAX_COLORS)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .vertex_count (vertex_count_reg),
        .color_count  (color_count_reg),
        .adj_ctl      (adj_ctl),
        .adj_wr_row   (adj_wr_row),
        .adj_wr_col   (adj_wr_col),
        .adj_rd_row   (adj_rd_row),
        .adj_rd_data  (adj_rd_data),
        .col_ctl      (col_ctl),
        .col_wr_addr  (col_wr_addr),
        .col_wr_data  (col_wr_data),
        .col_rd_addr  (col_rd_addr),
        .col_rd_data  (col_rd_data)
    );

endmodule

`default_nettype wire
